// ===== src/jsu_pkg.sv =====
// Shared types, constants and helper functions for the JSON string unescaper.
package jsu_pkg;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_BODY    = 3'd1,
        M_ESC     = 3'd2,
        M_HEX1    = 3'd3,
        M_WANT_BS = 3'd4,
        M_WANT_U  = 3'd5,
        M_HEX2    = 3'd6
    } mode_t;

    typedef enum logic [3:0] {
        ST_BYTE      = 4'd0,
        ST_DONE      = 4'd1,
        ST_NO_QUOTE  = 4'd2,
        ST_CTRL      = 4'd3,
        ST_BAD_ESC   = 4'd4,
        ST_BAD_HEX   = 4'd5,
        ST_LONE_LOW  = 4'd6,
        ST_NO_LOW    = 4'd7,
        ST_BAD_LOW   = 4'd8,
        ST_UNTERM    = 4'd9,
        ST_TRUNC_ESC = 4'd10,
        ST_TRUNC_UNI = 4'd11
    } status_t;

    localparam logic [15:0] SURR_HIGH_LO = 16'hd800;
    localparam logic [15:0] SURR_HIGH_HI = 16'hdbff;
    localparam logic [15:0] SURR_LOW_LO  = 16'hdc00;
    localparam logic [15:0] SURR_LOW_HI  = 16'hdfff;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam logic [20:0] TWO_BYTE_MAX = 21'h7ff;
    localparam logic [20:0] ONE_BYTE_END = 21'h80;

    localparam logic [7:0] LEAD2      = 8'hc0;
    localparam logic [7:0] LEAD3      = 8'he0;
    localparam logic [7:0] LEAD4      = 8'hf0;
    localparam logic [7:0] CONT       = 8'h80;
    localparam logic [7:0] SPACE_CODE = 8'h20;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_FF  = 8'h0c;
    localparam logic [7:0] CODE_LF  = 8'h0a;
    localparam logic [7:0] CODE_CR  = 8'h0d;
    localparam logic [7:0] CODE_TAB = 8'h09;

    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } utf8_seq_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(logic [7:0] c);
        hex_digit_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.value = c[3:0];
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            h.value = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    function automatic utf8_seq_t utf8_encode(logic [20:0] v);
        utf8_seq_t s;
        s.bytes = '0;
        if (v < ONE_BYTE_END) begin
            s.last_idx = 2'd0;
            s.bytes[0] = v[7:0];
        end else if (v <= TWO_BYTE_MAX) begin
            s.last_idx = 2'd1;
            s.bytes[0] = LEAD2 | 8'(v[10:6]);
            s.bytes[1] = CONT | 8'(v[5:0]);
        end else if (v < SUPP_BASE) begin
            s.last_idx = 2'd2;
            s.bytes[0] = LEAD3 | 8'(v[15:12]);
            s.bytes[1] = CONT | 8'(v[11:6]);
            s.bytes[2] = CONT | 8'(v[5:0]);
        end else begin
            s.last_idx = 2'd3;
            s.bytes[0] = LEAD4 | 8'(v[20:18]);
            s.bytes[1] = CONT | 8'(v[17:12]);
            s.bytes[2] = CONT | 8'(v[11:6]);
            s.bytes[3] = CONT | 8'(v[5:0]);
        end
        return s;
    endfunction

endpackage

// ===== src/json_string_unescape_utf8.sv =====
// JSON string literal unescaper: decodes escapes and emits UTF-8 bytes.
//
// Input channel (s_*): one raw byte of the literal per transfer, opening quote
// first. s_tuser flags that the data ended before this point (no byte then).
// Result channel (m_*): one UTF-8 byte or one status code per transfer;
// m_tlast marks the final result caused by an input byte.
//
// Each accepted byte is decoded in the same cycle and its results are registered
// into the output buffer. Plain bytes, short escapes, statuses and escape digits
// stream at one per cycle while m_tready is high. A completed \uXXXX code point
// yields one to four UTF-8 bytes that leave one per cycle while m_tready is high;
// s_tready stays low until the last of them is transferred.
// s_tready also rises in the cycle the final buffered result is taken.
//
// Reset returns the decoder to waiting for an opening quote and empties the
// output buffer. When the receiver stalls, the current result holds and new
// input waits once the buffer is full.
module json_string_unescape_utf8 (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [0:0] s_tuser,   // [0] input_ended
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [3:0] m_tuser,   // [3:0] status
    output logic       m_tlast
);
    import jsu_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [1:0] hex_cnt_reg, hex_cnt_next;
    logic [15:0] accum_reg, accum_next;
    logic [9:0] high_reg, high_next;

    logic [3:0][7:0] bytes_reg;
    status_t         status_reg;
    logic [1:0]      last_idx_reg;
    logic [1:0]      idx_reg;
    logic            valid_reg;

    logic            res_valid;
    status_t         res_status;
    utf8_seq_t       res_seq;

    logic [7:0]  in_byte;
    logic        ended;
    hex_digit_t  hex;
    logic [15:0] accum_shift;
    logic        out_done;
    logic        accept;

    assign in_byte     = s_tdata;
    assign ended       = s_tuser[0];
    assign hex         = hex_decode(in_byte);
    assign accum_shift = {accum_reg[11:0], hex.value};

    always_comb begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        accum_next   = accum_reg;
        high_next    = high_reg;
        res_valid    = 1'b0;
        res_status   = ST_BYTE;
        res_seq      = '0;

        case (mode_reg)
            M_BODY: begin
                if (ended) begin
                    res_valid  = 1'b1;
                    res_status = ST_UNTERM;
                end else if (in_byte == CH_QUOTE) begin
                    res_valid  = 1'b1;
                    res_status = ST_DONE;
                end else if (in_byte < SPACE_CODE) begin
                    res_valid  = 1'b1;
                    res_status = ST_CTRL;
                end else if (in_byte == CH_BSLASH) begin
                    mode_next = M_ESC;
                end else begin
                    res_valid        = 1'b1;
                    res_seq.bytes[0] = in_byte;
                end
            end
            M_ESC: begin
                if (ended) begin
                    res_valid  = 1'b1;
                    res_status = ST_TRUNC_ESC;
                end else begin
                    mode_next = M_BODY;
                    res_valid = 1'b1;
                    case (in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: res_seq.bytes[0] = in_byte;
                        CH_B: res_seq.bytes[0] = CODE_BS;
                        CH_F: res_seq.bytes[0] = CODE_FF;
                        CH_N: res_seq.bytes[0] = CODE_LF;
                        CH_R: res_seq.bytes[0] = CODE_CR;
                        CH_T: res_seq.bytes[0] = CODE_TAB;
                        CH_U: begin
                            res_valid    = 1'b0;
                            mode_next    = M_HEX1;
                            hex_cnt_next = 2'd0;
                            accum_next   = '0;
                        end
                        default: res_status = ST_BAD_ESC;
                    endcase
                end
            end
            M_HEX1, M_HEX2: begin
                if (ended) begin
                    res_valid  = 1'b1;
                    res_status = ST_TRUNC_UNI;
                end else if (!hex.valid) begin
                    res_valid  = 1'b1;
                    res_status = ST_BAD_HEX;
                end else if (hex_cnt_reg != 2'd3) begin
                    accum_next   = accum_shift;
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                end else begin
                    accum_next   = '0;
                    hex_cnt_next = 2'd0;
                    if (mode_reg == M_HEX1) begin
                        if (accum_shift >= SURR_HIGH_LO && accum_shift <= SURR_HIGH_HI) begin
                            high_next = accum_shift[9:0];
                            mode_next = M_WANT_BS;
                        end else if (accum_shift >= SURR_LOW_LO &&
                                     accum_shift <= SURR_LOW_HI) begin
                            res_valid  = 1'b1;
                            res_status = ST_LONE_LOW;
                        end else begin
                            res_valid = 1'b1;
                            res_seq   = utf8_encode({5'd0, accum_shift});
                            mode_next = M_BODY;
                        end
                    end else begin
                        if (accum_shift < SURR_LOW_LO || accum_shift > SURR_LOW_HI) begin
                            res_valid  = 1'b1;
                            res_status = ST_BAD_LOW;
                        end else begin
                            // 0x10000 + (high << 10) + low offset
                            res_valid = 1'b1;
                            res_seq   = utf8_encode({11'(high_reg) + 11'(SUPP_BASE[20:10]),
                                                     accum_shift[9:0]});
                            high_next = '0;
                            mode_next = M_BODY;
                        end
                    end
                end
            end
            M_WANT_BS: begin
                if (ended || in_byte != CH_BSLASH) begin
                    res_valid  = 1'b1;
                    res_status = ST_NO_LOW;
                end else begin
                    mode_next = M_WANT_U;
                end
            end
            M_WANT_U: begin
                if (ended || in_byte != CH_U) begin
                    res_valid  = 1'b1;
                    res_status = ST_NO_LOW;
                end else begin
                    mode_next    = M_HEX2;
                    hex_cnt_next = 2'd0;
                    accum_next   = '0;
                end
            end
            default: begin
                if (!ended && in_byte == CH_QUOTE) begin
                    mode_next    = M_BODY;
                    hex_cnt_next = 2'd0;
                    accum_next   = '0;
                    high_next    = '0;
                end else begin
                    res_valid  = 1'b1;
                    res_status = ST_NO_QUOTE;
                end
            end
        endcase

        // every status other than a byte drops back to waiting for a quote
        if (res_valid && res_status != ST_BYTE) begin
            mode_next    = M_IDLE;
            hex_cnt_next = 2'd0;
            accum_next   = '0;
            high_next    = '0;
        end
    end

    assign out_done = valid_reg && m_tready && (idx_reg == last_idx_reg);
    assign s_tready = !valid_reg || out_done;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= M_IDLE;
            hex_cnt_reg <= '0;
            accum_reg   <= '0;
            high_reg    <= '0;
            valid_reg   <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (accept) begin
                mode_reg    <= mode_next;
                hex_cnt_reg <= hex_cnt_next;
                accum_reg   <= accum_next;
                high_reg    <= high_next;
            end
            if (accept && res_valid) begin
                valid_reg <= 1'b1;
                idx_reg   <= '0;
            end else if (out_done) begin
                valid_reg <= 1'b0;
            end else if (valid_reg && m_tready) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // result payload: loaded only on a new result set
    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            bytes_reg    <= res_seq.bytes;
            last_idx_reg <= res_seq.last_idx;
            status_reg   <= res_status;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = bytes_reg[idx_reg];
    assign m_tuser  = status_reg;
    assign m_tlast  = (idx_reg == last_idx_reg);

endmodule

// ===== src/jsu_checker.sv =====
// Port-level checks for the JSON string unescaper, bound to the top level.
module jsu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [3:0] m_tuser,
    input logic       m_tlast
);
    import jsu_pkg::*;

    // a stalled result transfer holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_TRUNC_UNI)
        else $error("status code out of range");

    // a status result stands alone and carries a zero byte
    a_status_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_BYTE |-> m_tlast && m_tdata == 8'd0)
        else $error("status result not single or byte not zero");

    // input waits while a result set is still being drained
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken before result set drained");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== test/json_string_unescape_utf8_tb.sv =====
// Testbench for the JSON string unescaper: directed and random literals checked against a predictor.
module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES = 16;

    typedef struct {
        logic [7:0] data;
        status_t    status;
        logic       last;
    } out_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic [0:0] s_tuser = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;

    // decoded bytes and status codes still to arrive, oldest first
    out_item_t pending_out[$];
    out_item_t step_out[$];
    out_item_t want;

    // predictor state
    mode_t       dec_mode = M_IDLE;
    logic [1:0]  dec_digits = 2'd0;
    logic [15:0] dec_accum = 16'h0000;
    logic [9:0]  dec_high = 10'h000;

    logic [7:0] esc_letters [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

    int error_count = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int send_idle_pct = 15;
    int recv_idle_pct = 74;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    json_string_unescape_utf8 i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
        return -1;
    endfunction

    task automatic emit(input logic [7:0] data, input status_t status);
        out_item_t r;
        r.data = data;
        r.status = status;
        r.last = 1'b0;
        step_out = {step_out, r};
    endtask

    // report a status and go back to waiting for an opening quote
    task automatic close_literal(input status_t status);
        emit(8'h00, status);
        dec_mode = M_IDLE;
        dec_digits = 2'd0;
        dec_accum = 16'h0000;
        dec_high = 10'h000;
    endtask

    task automatic emit_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            emit(cp[7:0], ST_BYTE);
        end else if (cp <= 21'h7ff) begin
            emit(LEAD2 | {3'b000, cp[10:6]}, ST_BYTE);
            emit(CONT | {2'b00, cp[5:0]}, ST_BYTE);
        end else if (cp < 21'h10000) begin
            emit(LEAD3 | {4'b0000, cp[15:12]}, ST_BYTE);
            emit(CONT | {2'b00, cp[11:6]}, ST_BYTE);
            emit(CONT | {2'b00, cp[5:0]}, ST_BYTE);
        end else begin
            emit(LEAD4 | {5'b00000, cp[20:18]}, ST_BYTE);
            emit(CONT | {2'b00, cp[17:12]}, ST_BYTE);
            emit(CONT | {2'b00, cp[11:6]}, ST_BYTE);
            emit(CONT | {2'b00, cp[5:0]}, ST_BYTE);
        end
    endtask

    task automatic unescape_step(input logic [7:0] b, input logic ended);
        int nib;
        logic [15:0] v;
        out_item_t r;
        step_out.delete();
        nib = hex_nibble(b);
        case (dec_mode)
            M_BODY: begin
                if (ended) close_literal(ST_UNTERM);
                else if (b == CH_QUOTE) close_literal(ST_DONE);
                else if (b < SPACE_CODE) close_literal(ST_CTRL);
                else if (b == CH_BSLASH) dec_mode = M_ESC;
                else emit(b, ST_BYTE);
            end
            M_ESC: begin
                if (ended) begin
                    close_literal(ST_TRUNC_ESC);
                end else begin
                    dec_mode = M_BODY;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: emit(b, ST_BYTE);
                        CH_B: emit(CODE_BS, ST_BYTE);
                        CH_F: emit(CODE_FF, ST_BYTE);
                        CH_N: emit(CODE_LF, ST_BYTE);
                        CH_R: emit(CODE_CR, ST_BYTE);
                        CH_T: emit(CODE_TAB, ST_BYTE);
                        CH_U: begin
                            dec_mode = M_HEX1;
                            dec_digits = 2'd0;
                            dec_accum = 16'h0000;
                        end
                        default: close_literal(ST_BAD_ESC);
                    endcase
                end
            end
            M_HEX1, M_HEX2: begin
                if (ended) begin
                    close_literal(ST_TRUNC_UNI);
                end else if (nib < 0) begin
                    close_literal(ST_BAD_HEX);
                end else begin
                    dec_accum = {dec_accum[11:0], nib[3:0]};
                    if (dec_digits != 2'd3) begin
                        dec_digits = dec_digits + 2'd1;
                    end else begin
                        v = dec_accum;
                        dec_digits = 2'd0;
                        dec_accum = 16'h0000;
                        if (dec_mode == M_HEX1) begin
                            if (v >= SURR_HIGH_LO && v <= SURR_HIGH_HI) begin
                                dec_high = 10'(v - SURR_HIGH_LO);
                                dec_mode = M_WANT_BS;
                            end else if (v >= SURR_LOW_LO && v <= SURR_LOW_HI) begin
                                close_literal(ST_LONE_LOW);
                            end else begin
                                emit_code_point({5'b00000, v});
                                dec_mode = M_BODY;
                            end
                        end else if (v < SURR_LOW_LO || v > SURR_LOW_HI) begin
                            close_literal(ST_BAD_LOW);
                        end else begin
                            emit_code_point(SUPP_BASE + {1'b0, dec_high, 10'h000}
                                            + 21'(v - SURR_LOW_LO));
                            dec_high = 10'h000;
                            dec_mode = M_BODY;
                        end
                    end
                end
            end
            M_WANT_BS: begin
                if (ended || b != CH_BSLASH) close_literal(ST_NO_LOW);
                else dec_mode = M_WANT_U;
            end
            M_WANT_U: begin
                if (ended || b != CH_U) begin
                    close_literal(ST_NO_LOW);
                end else begin
                    dec_mode = M_HEX2;
                    dec_digits = 2'd0;
                    dec_accum = 16'h0000;
                end
            end
            default: begin
                if (!ended && b == CH_QUOTE) begin
                    dec_digits = 2'd0;
                    dec_accum = 16'h0000;
                    dec_high = 10'h000;
                    dec_mode = M_BODY;
                end else begin
                    close_literal(ST_NO_QUOTE);
                end
            end
        endcase
        foreach (step_out[i]) begin
            r = step_out[i];
            r.last = (i == step_out.size() - 1);
            pending_out = {pending_out, r};
        end
    endtask

    // ---------------------------------------------------------------- driving

    task automatic offer_byte(input logic [7:0] b, input logic ended);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= ended;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        unescape_step(b, ended);
        items_sent++;
    endtask

    task automatic stop_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_out.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // backslash, u and the leading digits of v
    task automatic offer_unicode(input logic [15:0] v, input int ndigits);
        offer_byte(CH_BSLASH, 1'b0);
        offer_byte(CH_U, 1'b0);
        for (int i = 0; i < ndigits; i++) offer_byte(hex_char(v[15 - 4 * i -: 4]), 1'b0);
    endtask

    task automatic offer_piece();
        logic [7:0] b;
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                b = 8'($urandom_range(SPACE_CODE, 255));
                if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h7e;
                offer_byte(b, 1'b0);
            end
            4, 5: begin
                offer_byte(CH_BSLASH, 1'b0);
                offer_byte(esc_letters[$urandom_range(0, 7)], 1'b0);
            end
            6, 7: begin
                case ($urandom_range(0, 3))
                    0: v = 16'($urandom_range(16'h0000, 16'h007f));
                    1: v = 16'($urandom_range(16'h0080, 16'h07ff));
                    2: v = 16'($urandom_range(16'h0800, 16'hd7ff));
                    default: v = 16'($urandom_range(16'he000, 16'hffff));
                endcase
                offer_unicode(v, 4);
            end
            default: begin
                offer_unicode(16'($urandom_range(SURR_HIGH_LO, SURR_HIGH_HI)), 4);
                offer_unicode(16'($urandom_range(SURR_LOW_LO, SURR_LOW_HI)), 4);
            end
        endcase
    endtask

    // end a literal with one of the malformed cases
    task automatic offer_fault();
        logic [7:0] b;
        logic [15:0] v;
        int k;
        b = 8'($urandom_range(255));
        v = 16'($urandom_range(16'hffff));
        k = $urandom_range(0, 3);
        case ($urandom_range(0, 10))
            0: offer_byte(b, 1'b1);
            1: offer_byte(8'($urandom_range(SPACE_CODE - 1)), 1'b0);
            2: begin
                if (b == CH_U) b = 8'h78;
                foreach (esc_letters[i]) if (b == esc_letters[i]) b = 8'h78;
                offer_byte(CH_BSLASH, 1'b0);
                offer_byte(b, 1'b0);
            end
            3: begin
                offer_byte(CH_BSLASH, 1'b0);
                offer_byte(b, 1'b1);
            end
            4: begin
                offer_unicode(v, k);
                offer_byte(b, 1'b1);
            end
            5: begin
                if (hex_nibble(b) >= 0) b = 8'h67;
                offer_unicode(v, k);
                offer_byte(b, 1'b0);
            end
            6: offer_unicode(16'($urandom_range(SURR_LOW_LO, SURR_LOW_HI)), 4);
            7: begin
                if (b == CH_BSLASH) b = 8'h71;
                offer_unicode(16'($urandom_range(SURR_HIGH_LO, SURR_HIGH_HI)), 4);
                offer_byte(b, 1'($urandom_range(1)));
            end
            8: begin
                if (b == CH_U) b = 8'h71;
                offer_unicode(16'($urandom_range(SURR_HIGH_LO, SURR_HIGH_HI)), 4);
                offer_byte(CH_BSLASH, 1'b0);
                offer_byte(b, 1'($urandom_range(1)));
            end
            9: begin
                if (v >= SURR_LOW_LO && v <= SURR_LOW_HI) v = v ^ 16'h2000;
                offer_unicode(16'($urandom_range(SURR_HIGH_LO, SURR_HIGH_HI)), 4);
                offer_unicode(v, 4);
            end
            default: begin
                offer_unicode(16'($urandom_range(SURR_HIGH_LO, SURR_HIGH_HI)), 4);
                offer_unicode(v, k);
                offer_byte(b, 1'b1);
            end
        endcase
    endtask

    task automatic offer_literal();
        int pieces;
        pieces = $urandom_range(0, 5);
        // occasional noise ahead of the opening quote
        if ($urandom_range(9) == 0) offer_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        offer_byte(CH_QUOTE, 1'b0);
        repeat (pieces) offer_piece();
        if ($urandom_range(99) < 70) offer_byte(CH_QUOTE, 1'b0);
        else offer_fault();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_no_quote();
        offer_byte(8'h61, 1'b0);
        offer_byte(8'hff, 1'b1);
    endtask

    task automatic test_raw_and_unterminated();
        offer_byte(CH_QUOTE, 1'b0);
        offer_byte(8'hff, 1'b0);
        offer_byte(8'h00, 1'b1);
    endtask

    task automatic test_truncated_escape();
        offer_byte(CH_QUOTE, 1'b0);
        offer_byte(CH_BSLASH, 1'b0);
        offer_byte(8'h5a, 1'b1);
    endtask

    task automatic test_surrogate_pair();
        offer_byte(CH_QUOTE, 1'b0);
        offer_byte(CH_BSLASH, 1'b0);
        offer_byte(CH_U, 1'b0);
        offer_byte("d", 1'b0);
        offer_byte("B", 1'b0);
        offer_byte("f", 1'b0);
        offer_byte("F", 1'b0);
        offer_byte(CH_BSLASH, 1'b0);
        offer_byte(CH_U, 1'b0);
        offer_byte("D", 1'b0);
        offer_byte("c", 1'b0);
        offer_byte("0", 1'b0);
        offer_byte("0", 1'b0);
        offer_byte(8'h00, 1'b0);
    endtask

    task automatic test_bad_hex();
        offer_byte(CH_QUOTE, 1'b0);
        offer_byte(CH_BSLASH, 1'b0);
        offer_byte(CH_U, 1'b0);
        offer_byte("G", 1'b0);
    endtask

    task automatic test_random_literals(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) offer_literal();
    endtask

    // stall the result side long enough for the block to push back on input
    task automatic test_output_stall();
        hold_seq++;
        offer_byte(CH_QUOTE, 1'b0);
        repeat (3) begin
            offer_unicode(16'($urandom_range(SURR_HIGH_LO, SURR_HIGH_HI)), 4);
            offer_unicode(16'($urandom_range(SURR_LOW_LO, SURR_LOW_HI)), 4);
        end
        offer_byte(CH_QUOTE, 1'b0);
    endtask

    task automatic test_sender_pause();
        repeat (3) begin
            offer_literal();
            stop_input();
            wait_drained();
        end
    endtask

    // ---------------------------------------------------------------- result side

    always @(negedge aclk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_out.size() == 0) begin
                $error("out_byte: nothing expected, got %02h (status %0d, last %0b)",
                       m_tdata, m_tuser, m_tlast);
                error_count++;
            end else begin
                want = pending_out.pop_front();
                if (m_tdata !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, m_tdata);
                    error_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("json_string_unescape_utf8_tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_no_quote();
        test_raw_and_unterminated();
        test_truncated_escape();
        test_surrogate_pair();
        test_bad_hex();

        test_random_literals(65);

        send_idle_pct = 74;
        recv_idle_pct = 15;
        test_random_literals(65);
        test_output_stall();
        test_sender_pause();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_literals(60);

        stop_input();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("json_string_unescape_utf8_tb: clean");
        end else begin
            $display("json_string_unescape_utf8_tb: errors");
        end
        $finish;
    end

endmodule
